[rtl/b58_pkg.sv]
// ----------------------------------------------------------------------------
// b58_pkg
// Shared types, constants and arithmetic helpers of the base58 encoder.
// ----------------------------------------------------------------------------
package b58_pkg;

    localparam int DIGIT_DEPTH = 61;    // base-58 digits held
    localparam int MAX_BYTES   = 44;    // longest accepted string
    localparam int CAP_LIMIT   = 62;    // capacity ceiling, terminator included
    localparam int ZERO_SAT    = 63;    // leading zero count saturation
    localparam int DIGIT_W     = 6;
    localparam int IDX_W       = 6;
    localparam int B58_RECIP   = 18079; // ceil(2^20 / 58)

    localparam logic [6:0] CHAR_ONE = 7'h31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FOLD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_CHECK,
        ST_ONES,
        ST_DIG_RD,
        ST_DIG_OUT,
        ST_ERR
    } t_b58_state;

    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [DIGIT_W-1:0] wr_data;
    } t_b58_mem_req;

    typedef struct packed {
        logic       load;
        logic [6:0] out_char;
        logic       last_char;
        logic       too_long;
    } t_b58_out_req;

    // x / 58 for x < 14848, by reciprocal multiply
    function automatic logic [7:0] b58_div58(input logic [13:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'(B58_RECIP);
        return p[27:20];
    endfunction

    // x - 58*q, with 58q = 64q - 4q - 2q
    function automatic logic [5:0] b58_rem58(input logic [13:0] x, input logic [7:0] q);
        logic [13:0] m;
        logic [13:0] r;
        m = {q, 6'b0} - {4'b0, q, 2'b0} - {5'b0, q, 1'b0};
        r = x - m;
        return r[5:0];
    endfunction

    // Bitcoin alphabet: 1-9, A-H, J-N, P-Z, a-k, m-z
    function automatic logic [6:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [6:0] c;
        if (d < 6'd9) begin
            c = 7'h31 + 7'(d);
        end else if (d < 6'd17) begin
            c = 7'h41 + 7'(d - 6'd9);
        end else if (d < 6'd22) begin
            c = 7'h4A + 7'(d - 6'd17);
        end else if (d < 6'd33) begin
            c = 7'h50 + 7'(d - 6'd22);
        end else if (d < 6'd44) begin
            c = 7'h61 + 7'(d - 6'd33);
        end else if (d < 6'd58) begin
            c = 7'h6D + 7'(d - 6'd44);
        end else begin
            c = 7'h00;
        end
        return c;
    endfunction

endpackage

[rtl/b58_if.sv]
// ----------------------------------------------------------------------------
// b58 channel interfaces
// Valid/ready channels for input bytes, output characters and configuration.
// ----------------------------------------------------------------------------
interface b58_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b58_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;
    logic       too_long;

    modport source (output valid, output out_char, output last_char, output too_long,
                    input ready);
    modport sink   (input valid, input out_char, input last_char, input too_long,
                    output ready);
endinterface

interface b58_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] max_output_chars;

    modport source (output valid, output max_output_chars, input ready);
    modport sink   (input valid, input max_output_chars, output ready);
endinterface

[rtl/b58_digit_ram.sv]
// ----------------------------------------------------------------------------
// b58_digit_ram
// Single-port-read, single-port-write digit memory, registered read data.
// ----------------------------------------------------------------------------
module b58_digit_ram (
    input  logic                        i_clk,
    input  b58_pkg::t_b58_mem_req       i_req,
    output logic [b58_pkg::DIGIT_W-1:0] o_rd_data
);
    import b58_pkg::*;

    logic [DIGIT_W-1:0] r_mem [0:DIGIT_DEPTH-1];
    logic [DIGIT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/b58_ctrl.sv]
// ----------------------------------------------------------------------------
// b58_ctrl
// Sequencer: folds bytes into the digit memory, scans, checks and emits.
// ----------------------------------------------------------------------------
module b58_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_byte,
    output logic                        o_in_ready,
    input  logic [5:0]                  i_max_chars,
    input  logic                        i_out_free,
    output b58_pkg::t_b58_out_req       o_out_req,
    output b58_pkg::t_b58_mem_req       o_mem_req,
    input  logic [b58_pkg::DIGIT_W-1:0] i_rd_data
);
    import b58_pkg::*;

    localparam logic [IDX_W-1:0] TOP_IDX  = IDX_W'(DIGIT_DEPTH - 1);
    localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(DIGIT_DEPTH);

    t_b58_state       r_state, n_state;
    logic [IDX_W-1:0] r_first, n_first;
    logic [5:0]       r_lzc, n_lzc;
    logic             r_inlz, n_inlz;
    logic [5:0]       r_bcnt, n_bcnt;
    logic             r_lost, n_lost;
    logic [7:0]       r_carry, n_carry;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_last, n_last;
    logic [IDX_W-1:0] r_start, n_start;
    logic [5:0]       r_ones, n_ones;

    logic               accept;
    logic               zero_lead;
    logic               fold_start;
    logic [DIGIT_W-1:0] fold_d;
    logic [13:0]        fold_x;
    logic [7:0]         fold_q;
    logic [DIGIT_W-1:0] fold_r;
    logic [IDX_W-1:0]   fold_first;
    logic               fold_more;
    logic [7:0]         total;
    logic [5:0]         cap;
    logic               too_long;
    logic               done;

    assign accept     = (r_state == ST_IDLE) && i_in_valid;
    assign zero_lead  = r_inlz && (i_data_byte == 8'd0);
    assign fold_start = !zero_lead && ((i_data_byte != 8'd0) || (r_first != NONE_IDX));

    // one multiply-by-256-and-carry step on digit r_idx
    // digits below the first used one are stale from earlier strings: read as 0
    assign fold_d     = (r_idx >= r_first) ? i_rd_data : '0;
    assign fold_x     = {fold_d, r_carry};
    assign fold_q     = b58_div58(fold_x);
    assign fold_r     = b58_rem58(fold_x, fold_q);
    assign fold_first = (r_idx < r_first) ? r_idx : r_first;
    assign fold_more  = (r_idx != '0) && ((fold_q != 8'd0) || (r_idx > fold_first));

    assign total    = 8'(r_lzc) + 8'(DIGIT_DEPTH) - 8'(r_start);
    assign cap      = (i_max_chars > 6'(CAP_LIMIT)) ? 6'(CAP_LIMIT) : i_max_chars;
    assign too_long = ((total + 8'd1) > 8'(cap)) || (r_bcnt > 6'(MAX_BYTES)) || r_lost;

    assign done = o_out_req.load && o_out_req.last_char;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (fold_start) begin
                        n_state = ST_FOLD;
                    end else if (i_last_byte) begin
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            ST_FOLD: begin
                if (!fold_more) begin
                    n_state = r_last ? ST_SCAN_RD : ST_IDLE;
                end
            end
            ST_SCAN_RD: begin
                n_state = (r_idx == NONE_IDX) ? ST_CHECK : ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                n_state = (i_rd_data == '0) ? ST_SCAN_RD : ST_CHECK;
            end
            ST_CHECK: begin
                if (too_long) begin
                    n_state = ST_ERR;
                end else begin
                    n_state = (r_lzc != '0) ? ST_ONES : ST_DIG_RD;
                end
            end
            ST_ONES: begin
                if (i_out_free && (r_ones == 6'd1)) begin
                    n_state = (r_start == NONE_IDX) ? ST_IDLE : ST_DIG_RD;
                end
            end
            ST_DIG_RD: begin
                n_state = ST_DIG_OUT;
            end
            ST_DIG_OUT: begin
                if (i_out_free) begin
                    n_state = (r_idx == TOP_IDX) ? ST_IDLE : ST_DIG_RD;
                end
            end
            ST_ERR: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready         = (r_state == ST_IDLE);
        o_mem_req          = '0;
        o_out_req          = '0;
        o_mem_req.wr_addr  = r_idx;
        o_mem_req.wr_data  = fold_r;
        o_mem_req.rd_addr  = r_idx;
        case (r_state)
            ST_IDLE: begin
                o_mem_req.rd_en   = accept && fold_start;
                o_mem_req.rd_addr = TOP_IDX;
            end
            ST_FOLD: begin
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.rd_en   = fold_more;
                o_mem_req.rd_addr = r_idx - IDX_W'(1);
            end
            ST_SCAN_RD: begin
                o_mem_req.rd_en = (r_idx != NONE_IDX);
            end
            ST_ONES: begin
                o_out_req.load      = i_out_free;
                o_out_req.out_char  = CHAR_ONE;
                o_out_req.last_char = (r_ones == 6'd1) && (r_start == NONE_IDX);
            end
            ST_DIG_RD: begin
                o_mem_req.rd_en = 1'b1;
            end
            ST_DIG_OUT: begin
                o_out_req.load      = i_out_free;
                o_out_req.out_char  = b58_char(i_rd_data);
                o_out_req.last_char = (r_idx == TOP_IDX);
            end
            ST_ERR: begin
                o_out_req.load      = i_out_free;
                o_out_req.last_char = 1'b1;
                o_out_req.too_long  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // string state
    always_comb begin
        n_first = r_first;
        n_lzc   = r_lzc;
        n_inlz  = r_inlz;
        n_bcnt  = r_bcnt;
        n_lost  = r_lost;
        n_carry = r_carry;
        n_idx   = r_idx;
        n_last  = r_last;
        n_start = r_start;
        n_ones  = r_ones;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_last = i_last_byte;
                    if (r_bcnt <= 6'(MAX_BYTES)) begin
                        n_bcnt = r_bcnt + 6'd1;
                    end
                    if (zero_lead) begin
                        if (r_lzc != 6'(ZERO_SAT)) begin
                            n_lzc = r_lzc + 6'd1;
                        end
                    end else begin
                        n_inlz = 1'b0;
                    end
                    n_carry = i_data_byte;
                    n_idx   = fold_start ? TOP_IDX : r_first;
                end
            end
            ST_FOLD: begin
                n_first = fold_first;
                n_carry = fold_q;
                if (fold_more) begin
                    n_idx = r_idx - IDX_W'(1);
                end else begin
                    n_lost = r_lost || (fold_q != 8'd0);
                    n_idx  = fold_first;
                end
            end
            ST_SCAN_RD: begin
                n_start = r_idx;
            end
            ST_SCAN_CHK: begin
                n_start = r_idx;
                if (i_rd_data == '0) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_CHECK: begin
                n_ones = r_lzc;
                n_idx  = r_start;
            end
            ST_ONES: begin
                if (i_out_free) begin
                    n_ones = r_ones - 6'd1;
                end
            end
            ST_DIG_OUT: begin
                if (i_out_free) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (done) begin
            n_first = NONE_IDX;
            n_lzc   = '0;
            n_inlz  = 1'b1;
            n_bcnt  = '0;
            n_lost  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_first <= NONE_IDX;
            r_lzc   <= '0;
            r_inlz  <= 1'b1;
            r_bcnt  <= '0;
            r_lost  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_lzc   <= n_lzc;
            r_inlz  <= n_inlz;
            r_bcnt  <= n_bcnt;
            r_lost  <= n_lost;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        r_idx   <= n_idx;
        r_last  <= n_last;
        r_start <= n_start;
        r_ones  <= n_ones;
    end

    // read-modify-write: every write goes to the entry read the cycle before
    a_rmw_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en |-> ($past(o_mem_req.rd_en) && o_mem_req.wr_addr == $past(o_mem_req.rd_addr)))
        else $error("digit write without matching read");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_req.load |-> i_out_free)
        else $error("result loaded into a full output register");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_state == ST_IDLE && r_first == NONE_IDX && r_lzc == '0 && r_inlz))
        else $error("string state not cleared after final result");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOLD && !fold_more && !r_last) |=> o_in_ready)
        else $error("block not ready after folding a middle byte");

endmodule

[rtl/base58_encoder.sv]
// ----------------------------------------------------------------------------
// base58_encoder
// Streaming Base58 encoder, Bitcoin alphabet, with capacity check.
//
//  channel  dir  payload                          handshake
//  i_in     in   data_byte[7:0], last_byte        valid/ready
//  o_out    out  out_char[6:0], last_char, too_long  valid/ready
//  i_cfg    in   max_output_chars[5:0]            valid/ready, ready always 1
//
// A byte past the leading zeros is folded in by read-modify-writes of the digit
// memory, one per cycle, set by its port. A leading zero byte is only counted.
// After the last byte, the scan skips zero digits, each in a read state and a
// check state, then emits one '1' per cycle while o_out is not stalled, and each
// digit by a memory read, then a load of the output register.
// Reset is synchronous; the digit memory needs no clearing pass.
// A stalled o_out holds the sequencer; the next string's bytes are taken once
// the final result sits in the output register.
// ----------------------------------------------------------------------------
module base58_encoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    b58_in_if.sink    i_in,
    b58_out_if.source o_out,
    b58_cfg_if.sink   i_cfg
);
    import b58_pkg::*;

    logic [5:0]         r_max_chars;
    logic               r_out_valid;
    logic [6:0]         r_out_char;
    logic               r_out_last;
    logic               r_out_err;
    logic               out_free;
    logic               in_ready;
    t_b58_out_req       out_req;
    t_b58_mem_req       mem_req;
    logic [DIGIT_W-1:0] rd_data;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign out_free    = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= 6'(CAP_LIMIT);
        end else if (i_cfg.valid) begin
            r_max_chars <= i_cfg.max_output_chars;
        end
    end

    b58_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_in_ready  (in_ready),
        .i_max_chars (r_max_chars),
        .i_out_free  (out_free),
        .o_out_req   (out_req),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data)
    );

    b58_digit_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_req.load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_req.load) begin
            r_out_char <= out_req.out_char;
            r_out_last <= out_req.last_char;
            r_out_err  <= out_req.too_long;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_char  = r_out_char;
    assign o_out.last_char = r_out_last;
    assign o_out.too_long  = r_out_err;

endmodule
